@@ design/dks_pkg.sv @@
// shared constants and types for the dictionary index key search unit
package dks_pkg;

	localparam int KEY_MAX_DEFAULT = 32;
	localparam int KEY_BYTES       = 32;
	localparam int KEY_WORDS       = 4;
	localparam int KEY_IDX_W       = 5;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [31:0] MAX_ENTRY_SIZE_RESET = 32'd32768;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_FOUND     = 2'd0;
	localparam status_t STATUS_NOT_FOUND = 2'd1;
	localparam status_t STATUS_REJECTED  = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_KEY_LENGTH = 3'd0;
	localparam cfg_idx_t REG_KEY_0_7    = 3'd1;
	localparam cfg_idx_t REG_KEY_8_15   = 3'd2;
	localparam cfg_idx_t REG_KEY_16_23  = 3'd3;
	localparam cfg_idx_t REG_KEY_24_31  = 3'd4;
	localparam cfg_idx_t REG_MAX_SIZE   = 3'd5;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

@@ design/dict_index_key_search_unit.sv @@
// top level of the dictionary index key search unit
// an accepted item waits in the input register, its result in the output register
// throughput: one item per cycle; the input register stalls only when its item makes a
// result while an earlier result waits in the output register and m_axis_tready is low
// reset: arst_n clears the parser to the headword phase, the key to empty and
// the size limit to 32768, and drops both valid flags at once
module dict_index_key_search_unit #(
	parameter int KEY_MAX = dks_pkg::KEY_MAX_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [dks_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // index_byte[7:0]
	input  logic                            s_axis_tlast,  // stream_end
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dks_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // status[1:0], entry_offset[33:2], entry_size[65:34], zero pad
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dks_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dks_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dks_pkg::*;

	localparam int CNT_W = $clog2(KEY_MAX + 2);
	localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(KEY_MAX + 1);
	localparam logic [5:0] KEY_MAX_6 = 6'(KEY_MAX);

	localparam logic [1:0] PH_WORD    = 2'd0;
	localparam logic [1:0] PH_TRAILER = 2'd1;
	localparam logic [1:0] PH_DONE    = 2'd2;

	// configuration
	logic [5:0]                       key_length_q;
	logic [KEY_WORDS-1:0][7:0][7:0]   key_q;
	logic [31:0]                      max_size_q;

	// input register
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 end_s1;

	// parser state
	logic [1:0]           phase_q;
	logic [CNT_W-1:0]     word_cnt_q;
	logic                 match_q;
	logic [2:0]           trl_cnt_q;
	logic [31:0]          offset_q;
	logic [31:0]          size_q;

	// output register
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [31:0]          out_offset_q;
	logic [31:0]          out_size_q;

	logic                 has_result;
	status_t              res_status;
	logic [31:0]          res_offset;
	logic [31:0]          res_size;
	logic                 adv_s1;

	logic [1:0]           phase_d;
	logic [CNT_W-1:0]     word_cnt_d;
	logic                 match_d;
	logic [2:0]           trl_cnt_d;
	logic [31:0]          offset_d;
	logic [31:0]          size_d;

	logic [KEY_IDX_W-1:0] key_idx;
	logic [7:0]           key_byte;
	logic [5:0]           word_cnt_6;
	logic [31:0]          size_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= '0;
			key_q        <= '0;
			max_size_q   <= MAX_ENTRY_SIZE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_LENGTH: key_length_q <= cfg_data[5:0];
				REG_KEY_0_7:    key_q[0] <= cfg_data;
				REG_KEY_8_15:   key_q[1] <= cfg_data;
				REG_KEY_16_23:  key_q[2] <= cfg_data;
				REG_KEY_24_31:  key_q[3] <= cfg_data;
				REG_MAX_SIZE:   max_size_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign key_idx    = KEY_IDX_W'(word_cnt_q);
	assign key_byte   = key_q[key_idx[KEY_IDX_W-1:3]][key_idx[2:0]];
	assign word_cnt_6 = 6'(word_cnt_q);
	assign size_next  = {size_q[23:0], byte_s1};

	always_comb begin
		phase_d    = phase_q;
		word_cnt_d = word_cnt_q;
		match_d    = match_q;
		trl_cnt_d  = trl_cnt_q;
		offset_d   = offset_q;
		size_d     = size_q;
		has_result = 1'b0;
		res_status = STATUS_NOT_FOUND;
		res_offset = '0;
		res_size   = '0;
		if (end_s1) begin
			has_result = (phase_q != PH_DONE);
			phase_d    = PH_WORD;
			word_cnt_d = '0;
			match_d    = 1'b1;
			trl_cnt_d  = '0;
			offset_d   = '0;
			size_d     = '0;
		end else begin
			unique case (phase_q)
				PH_WORD: begin
					if (byte_s1 == 8'd0) begin
						match_d   = match_q && key_length_q != 6'd0 &&
							key_length_q <= KEY_MAX_6 && word_cnt_6 == key_length_q;
						phase_d   = PH_TRAILER;
						trl_cnt_d = '0;
						offset_d  = '0;
						size_d    = '0;
					end else begin
						if (word_cnt_6 >= key_length_q || word_cnt_6 >= KEY_MAX_6 ||
							to_lower(byte_s1) != key_byte) begin
							match_d = 1'b0;
						end
						if (word_cnt_q < CNT_SAT) begin
							word_cnt_d = word_cnt_q + 1'b1;
						end
					end
				end
				PH_TRAILER: begin
					if (!trl_cnt_q[2]) begin
						offset_d = {offset_q[23:0], byte_s1};
					end else begin
						size_d = size_next;
					end
					trl_cnt_d = trl_cnt_q + 1'b1;
					if (trl_cnt_q == 3'd7) begin
						if (match_q) begin
							has_result = 1'b1;
							res_status = (size_next == 32'd0 || size_next > max_size_q) ?
								STATUS_REJECTED : STATUS_FOUND;
							res_offset = offset_q;
							res_size   = size_next;
							phase_d    = PH_DONE;
							trl_cnt_d  = '0;
						end else begin
							phase_d    = PH_WORD;
							word_cnt_d = '0;
							match_d    = 1'b1;
							trl_cnt_d  = '0;
							offset_d   = '0;
							size_d     = '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign adv_s1        = valid_s1 && (!has_result || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WORD;
			word_cnt_q <= '0;
			match_q    <= 1'b1;
			trl_cnt_q  <= '0;
			offset_q   <= '0;
			size_q     <= '0;
		end else if (adv_s1) begin
			phase_q    <= phase_d;
			word_cnt_q <= word_cnt_d;
			match_q    <= match_d;
			trl_cnt_q  <= trl_cnt_d;
			offset_q   <= offset_d;
			size_q     <= size_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			out_status_q <= res_status;
			out_offset_q <= res_offset;
			out_size_q   <= res_size;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_size_q, out_offset_q, out_status_q};

endmodule

@@ design/dks_checker.sv @@
// port-level checker for the dictionary index key search unit, bound to the top level
module dks_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dks_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import dks_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] == STATUS_FOUND ||
			m_axis_tdata[1:0] == STATUS_NOT_FOUND || m_axis_tdata[1:0] == STATUS_REJECTED))
		else $error("undefined status code");

	// not found carries no offset or size
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == STATUS_NOT_FOUND |-> m_axis_tdata[65:2] == '0)
		else $error("not found item with nonzero offset or size");

	// found with size zero must be rejected
	a_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == STATUS_FOUND |-> m_axis_tdata[65:34] != '0)
		else $error("zero size reported as found");

endmodule

bind dict_index_key_search_unit dks_checker u_dks_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
